/* design/rdp_pkg.sv */
// ----------------------------------------------------------------------------
// rdp_pkg
// Shared constants, microcode format, microprogram and digit helpers for the
// radix digit unit.
// ----------------------------------------------------------------------------
package rdp_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_DIGITS_DEF = 32;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;
    localparam int STEP_W  = 3;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'd48;
    localparam logic [CHAR_W-1:0]  CHAR_LETTER_A = 8'd65;
    localparam logic [DIGIT_W-1:0] TEN           = 6'd10;

    typedef logic [STEP_W-1:0] step_t;

    // microprogram addresses
    localparam step_t ST_DIV_INIT = 3'd0;
    localparam step_t ST_DIV_RUN  = 3'd1;
    localparam step_t ST_WR       = 3'd2;
    localparam step_t ST_PAL_RD   = 3'd3;
    localparam step_t ST_PAL_CMP  = 3'd4;
    localparam step_t ST_EMIT_RD  = 3'd5;
    localparam step_t ST_EMIT_LD  = 3'd6;
    localparam step_t ST_IDLE     = 3'd7;

    typedef enum logic [1:0] {
        H_NONE,
        H_NO_IN,
        H_DIV_RUN,
        H_OUT_FULL
    } hold_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_MORE_DIGITS,
        C_PAL_DONE,
        C_MORE_EMIT
    } cond_t;

    typedef struct packed {
        logic  in_rdy;
        logic  div_start;
        logic  div_step;
        logic  wr_digit;
        logic  pal_rd;
        logic  pal_cmp;
        logic  emit_rd;
        logic  emit_ld;
        hold_t hold;
        cond_t cond;
        step_t target;
    } cw_t;

    typedef struct packed {
        logic in_valid;
        logic div_last;
        logic more_digits;
        logic pal_done;
        logic out_full;
        logic more_emit;
    } seq_stat_t;

    typedef struct packed {
        logic start;
        logic step;
    } div_ctl_t;

    function automatic cw_t ucode(input step_t s);
        cw_t w;
        w = '0;
        w.hold   = H_NONE;
        w.cond   = C_NEVER;
        w.target = ST_IDLE;
        unique case (s)
            ST_DIV_INIT:
            begin
                w.div_start = 1'b1;
            end
            ST_DIV_RUN:
            begin
                w.div_step = 1'b1;
                w.hold     = H_DIV_RUN;
            end
            ST_WR:
            begin
                w.wr_digit = 1'b1;
                w.cond     = C_MORE_DIGITS;
                w.target   = ST_DIV_INIT;
            end
            ST_PAL_RD:
            begin
                w.pal_rd = 1'b1;
                w.cond   = C_PAL_DONE;
                w.target = ST_EMIT_RD;
            end
            ST_PAL_CMP:
            begin
                w.pal_cmp = 1'b1;
                w.cond    = C_ALWAYS;
                w.target  = ST_PAL_RD;
            end
            ST_EMIT_RD:
            begin
                w.emit_rd = 1'b1;
            end
            ST_EMIT_LD:
            begin
                w.emit_ld = 1'b1;
                w.hold    = H_OUT_FULL;
                w.cond    = C_MORE_EMIT;
                w.target  = ST_EMIT_RD;
            end
            ST_IDLE:
            begin
                w.in_rdy = 1'b1;
                w.hold   = H_NO_IN;
                w.cond   = C_ALWAYS;
                w.target = ST_DIV_INIT;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] e;
        if (r < RADIX_MIN)
        begin
            e = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            e = RADIX_MAX;
        end
        else
        begin
            e = r;
        end
        return e;
    endfunction

    function automatic logic [CHAR_W-1:0] to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < TEN)
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            c = CHAR_LETTER_A + CHAR_W'(d - TEN);
        end
        return c;
    endfunction

endpackage

/* design/rdp_in_if.sv */
// ----------------------------------------------------------------------------
// rdp_in_if
// Value channel: one beat carries one unsigned value to convert.
// ----------------------------------------------------------------------------
interface rdp_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* design/rdp_out_if.sv */
// ----------------------------------------------------------------------------
// rdp_out_if
// Digit channel: one beat carries one digit, most significant first.
// ----------------------------------------------------------------------------
interface rdp_out_if;
    import rdp_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  digit_char;
    logic [DIGIT_W-1:0] digit_value;
    logic               last_digit;
    logic               is_palindrome;

    modport source (output valid, output digit_char, output digit_value,
                    output last_digit, output is_palindrome, input ready);
    modport sink   (input valid, input digit_char, input digit_value,
                    input last_digit, input is_palindrome, output ready);
endinterface

/* design/rdp_divider.sv */
// ----------------------------------------------------------------------------
// rdp_divider
// Restoring divider by the radix, one quotient bit per cycle on ctl.step.
// ----------------------------------------------------------------------------
module rdp_divider #(
    parameter int VALUE_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rdp_pkg::div_ctl_t              ctl,
    input  logic [VALUE_BITS-1:0]          dividend,
    input  logic [rdp_pkg::RADIX_W-1:0]    radix,
    output logic [VALUE_BITS-1:0]          quotient,
    output logic [rdp_pkg::RADIX_W-1:0]    remainder,
    output logic                           last
);
    import rdp_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] quot_reg;
    logic [VALUE_BITS-1:0] quot_next;
    logic [RADIX_W-1:0]    prem_reg;
    logic [RADIX_W-1:0]    prem_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [RADIX_W:0]      trial;
    logic                  qbit;

    assign trial = {prem_reg, quot_reg[VALUE_BITS-1]};
    assign qbit  = (trial >= {1'b0, radix});

    always_comb
    begin
        quot_next = quot_reg;
        prem_next = prem_reg;
        cnt_next  = cnt_reg;
        if (ctl.start)
        begin
            quot_next = dividend;
            prem_next = '0;
            cnt_next  = CNT_W'(VALUE_BITS - 1);
        end
        else if (ctl.step)
        begin
            quot_next = {quot_reg[VALUE_BITS-2:0], qbit};
            prem_next = qbit ? RADIX_W'(trial - {1'b0, radix}) : trial[RADIX_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        prem_reg <= prem_next;
    end

    assign quotient  = quot_reg;
    assign remainder = prem_reg;
    assign last      = (cnt_reg == '0);

endmodule

/* design/rdp_digit_mem.sv */
// ----------------------------------------------------------------------------
// rdp_digit_mem
// Digit store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rdp_digit_mem #(
    parameter int DEPTH = 32
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [$clog2(DEPTH)-1:0]        waddr,
    input  logic [rdp_pkg::DIGIT_W-1:0]     wdata,
    input  logic                            ra_en,
    input  logic [$clog2(DEPTH)-1:0]        ra_addr,
    output logic [rdp_pkg::DIGIT_W-1:0]     ra_data,
    input  logic                            rb_en,
    input  logic [$clog2(DEPTH)-1:0]        rb_addr,
    output logic [rdp_pkg::DIGIT_W-1:0]     rb_data
);
    import rdp_pkg::*;

    logic [DIGIT_W-1:0] mem [DEPTH];
    logic [DIGIT_W-1:0] ra_reg;
    logic [DIGIT_W-1:0] rb_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (ra_en)
        begin
            ra_reg <= mem[ra_addr];
        end
        if (rb_en)
        begin
            rb_reg <= mem[rb_addr];
        end
    end

    assign ra_data = ra_reg;
    assign rb_data = rb_reg;

endmodule

/* design/rdp_seq.sv */
// ----------------------------------------------------------------------------
// rdp_seq
// Microcode sequencer: step counter, control ROM, hold and branch logic.
// ----------------------------------------------------------------------------
module rdp_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  rdp_pkg::seq_stat_t stat,
    output rdp_pkg::cw_t       cw,
    output logic               fire
);
    import rdp_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  hold;
    logic  taken;

    assign cw = ucode(step_reg);

    always_comb
    begin
        unique case (cw.hold)
            H_NONE:     hold = 1'b0;
            H_NO_IN:    hold = !stat.in_valid;
            H_DIV_RUN:  hold = !stat.div_last;
            H_OUT_FULL: hold = stat.out_full;
            default:    hold = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (cw.cond)
            C_NEVER:       taken = 1'b0;
            C_ALWAYS:      taken = 1'b1;
            C_MORE_DIGITS: taken = stat.more_digits;
            C_PAL_DONE:    taken = stat.pal_done;
            C_MORE_EMIT:   taken = stat.more_emit;
            default:       taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hold)
        begin
            step_next = step_reg;
        end
        else if (taken)
        begin
            step_next = cw.target;
        end
        else
        begin
            step_next = step_reg + step_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign fire = !hold;

endmodule

/* design/radix_digits_with_palindrome_unit.sv */
// ----------------------------------------------------------------------------
// radix_digits_with_palindrome_unit
// Converts a value to radix digits, most significant first, with a
// palindrome flag on every digit beat.
// All digits come from repeated division by the radix (one quotient bit per
// cycle in the shared divider), followed by a palindrome check over digit
// pairs and the digit beats through one read port; the receiver can stall
// the digit beats. A new value is taken only after the last beat is loaded.
// reset: sequencer idles, output empty, radix 10; digit store not cleared
// ----------------------------------------------------------------------------
module radix_digits_with_palindrome_unit #(
    parameter int VALUE_BITS = rdp_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = rdp_pkg::MAX_DIGITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rdp_pkg::RADIX_W-1:0] cfg_wdata,
    rdp_in_if.sink                      value_ch,
    rdp_out_if.source                   digit_ch
);
    import rdp_pkg::*;

    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

    cw_t                   cw;
    logic                  fire;
    seq_stat_t             stat;
    div_ctl_t              div_ctl;

    logic [RADIX_W-1:0]    radix_reg;
    logic [RADIX_W-1:0]    radix_eff;
    logic [VALUE_BITS-1:0] val_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [ADDR_W-1:0]     i_reg;
    logic [ADDR_W-1:0]     j_reg;
    logic [ADDR_W-1:0]     k_reg;
    logic                  pal_reg;

    logic                  out_vld_reg;
    logic [CHAR_W-1:0]     out_char_reg;
    logic [DIGIT_W-1:0]    out_digit_reg;
    logic                  out_last_reg;
    logic                  out_pal_reg;

    logic [VALUE_BITS-1:0] quotient;
    logic [RADIX_W-1:0]    remainder;
    logic                  div_last;
    logic [DIGIT_W-1:0]    ra_data;
    logic [DIGIT_W-1:0]    rb_data;
    logic                  out_load;

    assign radix_eff = eff_radix(radix_reg);

    assign div_ctl.start = cw.div_start;
    assign div_ctl.step  = cw.div_step;

    assign stat.in_valid    = value_ch.valid;
    assign stat.div_last    = div_last;
    assign stat.more_digits = (quotient != '0) && ((n_reg + CNT_W'(1)) < CNT_W'(MAX_DIGITS));
    assign stat.pal_done    = (i_reg >= j_reg);
    assign stat.out_full    = out_vld_reg && !digit_ch.ready;
    assign stat.more_emit   = (k_reg != '0);

    assign out_load = cw.emit_ld && fire;

    rdp_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cw    (cw),
        .fire  (fire)
    );

    rdp_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .dividend  (val_reg),
        .radix     (radix_eff),
        .quotient  (quotient),
        .remainder (remainder),
        .last      (div_last)
    );

    rdp_digit_mem #(
        .DEPTH (MAX_DIGITS)
    ) u_mem (
        .clk     (clk),
        .we      (cw.wr_digit),
        .waddr   (n_reg[ADDR_W-1:0]),
        .wdata   (remainder),
        .ra_en   (cw.pal_rd || cw.emit_rd),
        .ra_addr (cw.emit_rd ? k_reg : i_reg),
        .ra_data (ra_data),
        .rb_en   (cw.pal_rd),
        .rb_addr (j_reg),
        .rb_data (rb_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg   <= RADIX_RESET;
            n_reg       <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                radix_reg <= cfg_wdata;
            end
            if (cw.in_rdy && fire)
            begin
                n_reg <= '0;
            end
            else if (cw.wr_digit)
            begin
                n_reg <= n_reg + CNT_W'(1);
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (digit_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw.in_rdy && fire)
        begin
            val_reg <= value_ch.value;
        end
        else if (cw.wr_digit)
        begin
            val_reg <= quotient;
        end
        if (cw.wr_digit)
        begin
            i_reg   <= '0;
            j_reg   <= n_reg[ADDR_W-1:0];
            k_reg   <= n_reg[ADDR_W-1:0];
            pal_reg <= 1'b1;
        end
        else if (cw.pal_cmp)
        begin
            i_reg <= i_reg + ADDR_W'(1);
            j_reg <= j_reg - ADDR_W'(1);
            if (ra_data != rb_data)
            begin
                pal_reg <= 1'b0;
            end
        end
        else if (out_load)
        begin
            k_reg <= k_reg - ADDR_W'(1);
        end
        if (out_load)
        begin
            out_char_reg  <= to_char(ra_data);
            out_digit_reg <= ra_data;
            out_last_reg  <= (k_reg == '0);
            out_pal_reg   <= pal_reg;
        end
    end

    assign value_ch.ready         = cw.in_rdy;
    assign digit_ch.valid         = out_vld_reg;
    assign digit_ch.digit_char    = out_char_reg;
    assign digit_ch.digit_value   = out_digit_reg;
    assign digit_ch.last_digit    = out_last_reg;
    assign digit_ch.is_palindrome = out_pal_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cw.wr_digit |-> (n_reg < CNT_W'(MAX_DIGITS)))
        else $error("digit written past the store depth");

    a_pal_order: assert property (@(posedge clk) disable iff (!rst_n)
        cw.pal_cmp |-> (i_reg < j_reg))
        else $error("palindrome compare with crossed pointers");

    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (k_reg == '0)) |=> value_ch.ready)
        else $error("sequencer not idle after the last digit beat");

endmodule
